// ----- sv/stgq_pkg.sv -----
// Shared types, constants and control records for the tone, gain and quantizer block.
package stgq_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_BASS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TREBLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 2'd2;

  localparam int GAIN_W   = 20;
  localparam int VOL_W    = 16;
  localparam int SAMPLE_W = 16;
  localparam logic [VOL_W-1:0] VOLUME_RESET = 16'd256;

  // Q2.22 working values
  localparam int Y_W   = 25;  // tone value, held within +/- 2^23
  localparam int D_W   = 26;  // difference from previous shaped sample
  localparam int S_W   = 24;  // shaped value, within +/- 1.0
  localparam int G_W   = 23;  // magnitude after volume, up to 1.0
  localparam int SUM_W = 38;  // accumulate before saturation

  localparam logic signed [Y_W-1:0] Y_LIMIT = 25'sd8388608;
  localparam logic signed [S_W-1:0] ONE_Q22 = 24'sd4194304;
  localparam logic [G_W-1:0]        G_ONE   = 23'd4194304;

  // Shared multiplier
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 20;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam logic [MUL_B_W-1:0] PCM_SCALE = 20'd32767;

  localparam int BASS_POS_SHIFT = 9;   // /2560 = /512 then /5
  localparam int BASS_NEG_SHIFT = 10;  // /5120 = /1024 then /5
  localparam int TREBLE_SHIFT   = 9;
  localparam int VOL_SHIFT      = 8;
  localparam int PCM_SHIFT      = 22;

  // Divide-by-five unit, four quotient bits per cycle
  localparam int DQ_W        = PROD_W - BASS_POS_SHIFT;
  localparam int DIV_BITS    = 4;
  localparam int DIV_STEPS   = DQ_W / DIV_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
  localparam int REM_W       = 3;
  localparam logic [REM_W:0] DIVISOR = 4'd5;

  localparam logic signed [SAMPLE_W-1:0] PCM_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] PCM_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    MUL_BASS,
    MUL_TREBLE,
    MUL_VOLUME,
    MUL_PCM
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BMUL,
    ST_BDIV,
    ST_BADD,
    ST_TMUL,
    ST_TDIV,
    ST_TADD,
    ST_SAT,
    ST_VMUL,
    ST_VCLAMP,
    ST_PMUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_step;
    logic     y_add;
    logic     s_store;
    logic     g_store;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic bass_zero;
    logic treble_on;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- sv/stgq_ctrl.sv -----
// Sequencer that steps one request through the shared multiplier and divider.
module stgq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  stgq_pkg::dp_sts_t sts,
  output stgq_pkg::dp_cmd_t cmd
);

  stgq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stgq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = stgq_pkg::MUL_BASS;
    in_stall    = (state_r != stgq_pkg::ST_IDLE);
    unique case (state_r)
      stgq_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stgq_pkg::ST_BMUL;
        end
      end
      stgq_pkg::ST_BMUL: begin
        if (sts.bass_zero) begin
          state_nxt = sts.treble_on ? stgq_pkg::ST_TMUL : stgq_pkg::ST_SAT;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = stgq_pkg::MUL_BASS;
          state_nxt   = stgq_pkg::ST_BDIV;
        end
      end
      stgq_pkg::ST_BDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = stgq_pkg::ST_BADD;
      end
      stgq_pkg::ST_BADD: begin
        cmd.y_add = 1'b1;
        state_nxt = sts.treble_on ? stgq_pkg::ST_TMUL : stgq_pkg::ST_SAT;
      end
      stgq_pkg::ST_TMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = stgq_pkg::MUL_TREBLE;
        state_nxt   = stgq_pkg::ST_TDIV;
      end
      stgq_pkg::ST_TDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = stgq_pkg::ST_TADD;
      end
      stgq_pkg::ST_TADD: begin
        cmd.y_add = 1'b1;
        state_nxt = stgq_pkg::ST_SAT;
      end
      stgq_pkg::ST_SAT: begin
        cmd.s_store = 1'b1;
        state_nxt   = stgq_pkg::ST_VMUL;
      end
      stgq_pkg::ST_VMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = stgq_pkg::MUL_VOLUME;
        state_nxt   = stgq_pkg::ST_VCLAMP;
      end
      stgq_pkg::ST_VCLAMP: begin
        cmd.g_store = 1'b1;
        state_nxt   = stgq_pkg::ST_PMUL;
      end
      stgq_pkg::ST_PMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = stgq_pkg::MUL_PCM;
        state_nxt   = stgq_pkg::ST_OUT;
      end
      stgq_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = stgq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stgq_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- sv/stgq_datapath.sv -----
// Datapath: config registers, shared multiplier, divide-by-five unit, history and output register.
module stgq_datapath #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [stgq_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [stgq_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_channel,
  input  logic signed [stgq_pkg::SAMPLE_W-1:0]   in_sample_in,
  input  logic                                   in_first_of_channel,
  input  stgq_pkg::dp_cmd_t                      cmd,
  output stgq_pkg::dp_sts_t                      sts,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic                                   out_channel_out,
  output logic signed [stgq_pkg::SAMPLE_W-1:0]   out_sample_out
);

  localparam int SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int Y_W    = stgq_pkg::Y_W;
  localparam int D_W    = stgq_pkg::D_W;
  localparam int S_W    = stgq_pkg::S_W;
  localparam int G_W    = stgq_pkg::G_W;
  localparam int SUM_W  = stgq_pkg::SUM_W;
  localparam int A_W    = stgq_pkg::MUL_A_W;
  localparam int B_W    = stgq_pkg::MUL_B_W;
  localparam int P_W    = stgq_pkg::PROD_W;
  localparam int DQ_W   = stgq_pkg::DQ_W;
  localparam int REM_W  = stgq_pkg::REM_W;
  localparam int CNT_W  = stgq_pkg::DIV_CNT_W;

  // Config registers
  logic signed [stgq_pkg::GAIN_W-1:0] bass_r, treble_r;
  logic [stgq_pkg::VOL_W-1:0]         volume_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bass_r   <= '0;
      treble_r <= '0;
      volume_r <= stgq_pkg::VOLUME_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        stgq_pkg::CFG_BASS:   bass_r   <= cfg_data;
        stgq_pkg::CFG_TREBLE: treble_r <= cfg_data;
        stgq_pkg::CFG_VOLUME: volume_r <= cfg_data[stgq_pkg::VOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Request registers
  logic              ch_r, first_r;
  logic [SLOT_W-1:0] slot_r, slot_in;
  logic signed [Y_W-1:0] y_r;

  assign slot_in = (NUM_CHANNELS == 1) ? '0 : SLOT_W'(in_channel);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r    <= in_channel;
      first_r <= in_first_of_channel;
      slot_r  <= slot_in;
    end
  end

  // Previous shaped sample per channel; valid bits stand in for the zero reset
  logic signed [S_W-1:0] prev_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] prev_vld_r;
  logic signed [S_W-1:0] prev_rd_r, prev;
  logic                  prev_ok_r;
  logic signed [S_W-1:0] s_r;

  always_ff @(posedge clk) begin
    if (cmd.load) prev_rd_r <= prev_mem[slot_in];
    if (cmd.s_store) prev_mem[slot_r] <= s_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_vld_r <= '0;
    end else if (cmd.s_store) begin
      prev_vld_r[slot_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) prev_ok_r <= prev_vld_r[slot_in];
  end

  assign prev = prev_ok_r ? prev_rd_r : '0;

  // Status
  logic bass_neg, treble_pos;
  assign bass_neg   = bass_r[stgq_pkg::GAIN_W-1];
  assign treble_pos = !treble_r[stgq_pkg::GAIN_W-1] && (treble_r != '0);

  // Operand selection for the shared multiplier
  logic signed [Y_W:0]   y_ext;
  logic signed [D_W-1:0] d_val;
  logic signed [S_W:0]   s_ext;
  logic [A_W-1:0]        y_abs, d_abs, s_abs;
  logic [B_W-1:0]        bass_abs;
  logic [G_W-1:0]        gmag_r;
  logic                  g_neg_r;
  logic [A_W-1:0]        mul_a;
  logic [B_W-1:0]        mul_b;
  logic                  mul_neg;
  logic [P_W-1:0]        prod, prod_r;
  logic                  prod_neg_r;

  assign y_ext    = {y_r[Y_W-1], y_r};
  assign d_val    = D_W'(y_r) - D_W'(prev);
  assign s_ext    = {s_r[S_W-1], s_r};
  assign y_abs    = A_W'(y_r[Y_W-1] ? -y_ext : y_ext);
  assign d_abs    = A_W'(d_val[D_W-1] ? -d_val : d_val);
  assign s_abs    = A_W'(s_r[S_W-1] ? -s_ext : s_ext);
  assign bass_abs = bass_neg ? (~bass_r + 1'b1) : bass_r;

  always_comb begin
    case (cmd.mul_sel)
      stgq_pkg::MUL_BASS: begin
        mul_a   = y_abs;
        mul_b   = bass_abs;
        mul_neg = y_r[Y_W-1] ^ bass_neg;
      end
      stgq_pkg::MUL_TREBLE: begin
        mul_a   = d_abs;
        mul_b   = treble_r;
        mul_neg = d_val[D_W-1];
      end
      stgq_pkg::MUL_VOLUME: begin
        mul_a   = s_abs;
        mul_b   = B_W'(volume_r);
        mul_neg = s_r[S_W-1];
      end
      stgq_pkg::MUL_PCM: begin
        mul_a   = A_W'(gmag_r);
        mul_b   = stgq_pkg::PCM_SCALE;
        mul_neg = g_neg_r;
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  assign prod = P_W'(mul_a) * P_W'(mul_b);

  // Divide-by-five, quotient shifts in from the bottom
  logic [DQ_W-1:0]  dq_r, dq_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r;

  always_comb begin
    logic [REM_W:0] trial;
    dq_nxt  = dq_r;
    rem_nxt = rem_r;
    for (int i = 0; i < stgq_pkg::DIV_BITS; i++) begin
      trial  = {rem_nxt, dq_nxt[DQ_W-1]};
      dq_nxt = {dq_nxt[DQ_W-2:0], 1'b0};
      if (trial >= stgq_pkg::DIVISOR) begin
        trial     = trial - stgq_pkg::DIVISOR;
        dq_nxt[0] = 1'b1;
      end
      rem_nxt = trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r     <= prod;
      prod_neg_r <= mul_neg;
      rem_r      <= '0;
      cnt_r      <= '0;
      if (cmd.mul_sel == stgq_pkg::MUL_BASS && bass_neg) begin
        dq_r <= DQ_W'(prod >> stgq_pkg::BASS_NEG_SHIFT);
      end else begin
        dq_r <= DQ_W'(prod >> stgq_pkg::TREBLE_SHIFT);
      end
    end else if (cmd.div_step) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // y accumulate with saturation at twice full scale
  logic signed [SUM_W-1:0] term, sum;
  logic signed [Y_W-1:0]   y_sat;

  assign term = prod_neg_r ? -SUM_W'(dq_r) : SUM_W'(dq_r);
  assign sum  = SUM_W'(y_r) + term;

  always_comb begin
    if (sum > SUM_W'(stgq_pkg::Y_LIMIT)) begin
      y_sat = stgq_pkg::Y_LIMIT;
    end else if (sum < -SUM_W'(stgq_pkg::Y_LIMIT)) begin
      y_sat = -stgq_pkg::Y_LIMIT;
    end else begin
      y_sat = Y_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      y_r <= {{2{in_sample_in[stgq_pkg::SAMPLE_W-1]}}, in_sample_in, 7'b0};
    end else if (cmd.y_add) begin
      y_r <= y_sat;
    end
  end

  // Clamp to +/- 1.0
  logic signed [S_W-1:0] s_nxt;

  always_comb begin
    if (y_r > Y_W'(stgq_pkg::ONE_Q22)) begin
      s_nxt = stgq_pkg::ONE_Q22;
    end else if (y_r < -Y_W'(stgq_pkg::ONE_Q22)) begin
      s_nxt = -stgq_pkg::ONE_Q22;
    end else begin
      s_nxt = S_W'(y_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.s_store) s_r <= s_nxt;
  end

  // Volume result magnitude, saturated at 1.0
  logic [P_W-1:0] vol_mag;
  assign vol_mag = prod_r >> stgq_pkg::VOL_SHIFT;

  always_ff @(posedge clk) begin
    if (cmd.g_store) begin
      g_neg_r <= prod_neg_r;
      gmag_r  <= (vol_mag >= P_W'(stgq_pkg::G_ONE)) ? stgq_pkg::G_ONE : G_W'(vol_mag);
    end
  end

  // PCM conversion and output register
  logic [stgq_pkg::SAMPLE_W-1:0]        pcm_mag;
  logic signed [stgq_pkg::SAMPLE_W-1:0] pcm;
  logic                                 out_valid_r, out_channel_r;
  logic signed [stgq_pkg::SAMPLE_W-1:0] out_sample_r;

  assign pcm_mag = stgq_pkg::SAMPLE_W'(prod_r >> stgq_pkg::PCM_SHIFT);

  always_comb begin
    if (gmag_r == stgq_pkg::G_ONE) begin
      pcm = g_neg_r ? stgq_pkg::PCM_MIN : stgq_pkg::PCM_MAX;
    end else begin
      pcm = g_neg_r ? -$signed(pcm_mag) : $signed(pcm_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_channel_r <= ch_r;
      out_sample_r  <= pcm;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel_out = out_channel_r;
  assign out_sample_out  = out_sample_r;

  assign sts.bass_zero = (bass_r == '0);
  assign sts.treble_on = treble_pos && !first_r;
  assign sts.div_last  = (cnt_r == CNT_W'(stgq_pkg::DIV_STEPS - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

`ifndef NO_ASSERTIONS
  // new result never overwrites one still waiting
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while stalled");

  // shaped value lands inside +/- 1.0
  a_s_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.s_store |=> (s_r <= stgq_pkg::ONE_Q22 && s_r >= -stgq_pkg::ONE_Q22))
    else $error("shaped value out of range");

  // accumulate only right after the last divider step
  a_add_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.y_add |-> $past(cmd.div_step))
    else $error("accumulate without finished quotient");
`endif

endmodule

// ----- sv/sample_tone_gain_quantizer_core.sv -----
// Top level of the tone, gain and PCM quantizer block.
//
// One request carries a Q1.15 sample and its channel; one PCM result comes
// back per request, in order. The sample is scaled by the bass gain, gets
// the treble emphasis against the channel's previous shaped sample (skipped
// on a channel's first sample or when treble is not positive), is clamped
// to +/-1.0, scaled by volume, clamped again and converted to 16-bit PCM.
// Rate: one request at a time through a single shared 25x20 multiplier and
// a divide-by-five unit that produces four quotient bits per cycle. Each
// active gain (bass, treble) adds a multiply, a divide and an accumulate
// step to a request; in_stall is high in every state but idle. The result
// sits in an output register, so the next request is accepted while it
// waits; the sequencer only holds in its last step if the previous result
// is still stalled. Channel history is a small per-channel store with
// valid bits cleared at reset, so no clearing pass is needed.
// Configuration writes (bass 0, treble 1, volume 2; other indexes ignored)
// take effect at once and are meant for idle periods.
module sample_tone_gain_quantizer_core #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [stgq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stgq_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_channel,
  input  logic signed [stgq_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                 in_first_of_channel,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_channel_out,
  output logic signed [stgq_pkg::SAMPLE_W-1:0] out_sample_out
);

  stgq_pkg::dp_cmd_t cmd;
  stgq_pkg::dp_sts_t sts;

  // sequencer
  stgq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic, history and output register
  stgq_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_channel          (in_channel),
    .in_sample_in        (in_sample_in),
    .in_first_of_channel (in_first_of_channel),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_channel_out     (out_channel_out),
    .out_sample_out      (out_sample_out)
  );

endmodule

// ----- bench/stgq_pcm_checker.sv -----
// Result checker for the tone, gain and PCM quantizer: predicts each PCM sample and compares.
module stgq_pcm_checker
  import stgq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_channel,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic                       in_first_of_channel,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_channel_out,
  input  logic signed [SAMPLE_W-1:0] out_sample_out,
  output int                         error_count,
  output int                         results_pending
);

  localparam longint UNIT_Q22 = 64'sd4194304;

  typedef struct packed {
    logic                       chan;
    logic signed [SAMPLE_W-1:0] pcm;
  } pcm_result_t;

  logic signed [GAIN_W-1:0] bass_q;
  logic signed [GAIN_W-1:0] treble_q;
  logic [VOL_W-1:0]         volume_q;
  logic signed [S_W-1:0]    prev_shaped [2];
  pcm_result_t              pcm_expected_q [$];

  initial begin
    error_count     = 0;
    results_pending = 0;
  end

  function automatic longint clamp_unit(input longint v);
    if (v > UNIT_Q22) return UNIT_Q22;
    if (v < -UNIT_Q22) return -UNIT_Q22;
    return v;
  endfunction

  // Tone shaping, volume and PCM conversion; updates the channel history.
  function automatic pcm_result_t predict_pcm(input logic chan,
                                              input logic signed [SAMPLE_W-1:0] smp,
                                              input logic first);
    longint x22, b, t, y, s, g, pcm;
    pcm_result_t r;
    x22 = longint'(smp) * 128;
    b   = longint'(bass_q);
    t   = longint'(treble_q);
    y   = x22;
    if (b > 0) y = x22 + (x22 * b) / 2560;
    else if (b < 0) y = x22 + (x22 * b) / 5120;
    if (t > 0 && !first) y = y + ((y - longint'(prev_shaped[chan])) * t) / 2560;
    s = clamp_unit(y);
    prev_shaped[chan] = s[S_W-1:0];
    g = clamp_unit((s * longint'(volume_q)) / 256);
    if (g >= UNIT_Q22) pcm = 32767;
    else if (g <= -UNIT_Q22) pcm = -32768;
    else pcm = (g * 32767) / UNIT_Q22;
    r.chan = chan;
    r.pcm  = pcm[SAMPLE_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    pcm_result_t want;
    if (!rst_n) begin
      bass_q         = '0;
      treble_q       = '0;
      volume_q       = VOLUME_RESET;
      prev_shaped[0] = '0;
      prev_shaped[1] = '0;
      pcm_expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASS:   bass_q = cfg_data[GAIN_W-1:0];
          CFG_TREBLE: treble_q = cfg_data[GAIN_W-1:0];
          CFG_VOLUME: volume_q = cfg_data[VOL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        pcm_expected_q.push_back(predict_pcm(in_channel, in_sample_in, in_first_of_channel));
      if (out_valid && !out_stall) begin
        if (pcm_expected_q.size() == 0) begin
          $error("unexpected result: channel_out %0d, sample_out %0d",
                 out_channel_out, out_sample_out);
          error_count = error_count + 1;
        end else begin
          want = pcm_expected_q.pop_front();
          if (out_channel_out !== want.chan) begin
            $error("channel_out: expected %0d, got %0d", want.chan, out_channel_out);
            error_count = error_count + 1;
          end
          if (out_sample_out !== want.pcm) begin
            $error("sample_out: expected %0d, got %0d", want.pcm, out_sample_out);
            error_count = error_count + 1;
          end
        end
      end
    end
    results_pending <= pcm_expected_q.size();
  end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the tone, gain and PCM quantizer: stimulus, receiver stalls and verdict.
module tb;
  import stgq_pkg::*;

  // Index past the register list; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int RANDOM_PHASES    = 10;
  localparam int PHASE_REQUESTS   = 110;
  localparam int LONG_HOLD_CYCLES = 300;
  // Leave room for the output register to drain after the worst request.
  localparam int DRAIN_CYCLES     = 40;
  localparam int CYCLE_LIMIT      = 400000;

  localparam logic [GAIN_W-1:0] GAIN_MAX = 20'h7ffff;
  localparam logic [GAIN_W-1:0] GAIN_MIN = 20'h80000;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_channel;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       in_first_of_channel;
  logic                       out_valid;
  logic                       out_stall;
  logic                       out_channel_out;
  logic signed [SAMPLE_W-1:0] out_sample_out;

  int error_count;
  int results_pending;
  int cycle_count = 0;

  // Receiver control
  logic hold_req;
  bit   hold_done;
  int   hold_left;
  int   stall_mode;
  int   mode_left;

  sample_tone_gain_quantizer_core #(
    .NUM_CHANNELS(2)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_channel         (in_channel),
    .in_sample_in       (in_sample_in),
    .in_first_of_channel(in_first_of_channel),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_channel_out    (out_channel_out),
    .out_sample_out     (out_sample_out)
  );

  stgq_pcm_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_channel         (in_channel),
    .in_sample_in       (in_sample_in),
    .in_first_of_channel(in_first_of_channel),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_channel_out    (out_channel_out),
    .out_sample_out     (out_sample_out),
    .error_count        (error_count),
    .results_pending    (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: generous bound on the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: one out_stall update per falling edge. Either a long hold-off
  // (requested once by the stimulus so the block backs up into in_stall) or
  // a stall pattern that is redrawn at random when its random run ends.
  initial begin
    out_stall  <= 1'b0;
    hold_done  = 1'b0;
    hold_left  = 0;
    stall_mode = 0;
    mode_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(16, 96);
        end
        mode_left = mode_left - 1;
        case (stall_mode)
          0: out_stall <= 1'b0;                          // free flow
          1: out_stall <= ($urandom_range(0, 3) == 0);   // light
          2: out_stall <= ($urandom_range(0, 3) != 0);   // heavy
          default: out_stall <= (mode_left % 3 == 0);    // periodic
        endcase
      end
    end
  end

  // Offer one request and hold it until accepted. Called and returns at a
  // falling edge.
  task automatic push_sample(input logic chan, input logic signed [SAMPLE_W-1:0] smp,
                             input logic first);
    in_valid            <= 1'b1;
    in_channel          <= chan;
    in_sample_in        <= smp;
    in_first_of_channel <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Back-to-back writes of all three config registers, then release the port.
  task automatic program_regs(input logic [GAIN_W-1:0] bass, input logic [GAIN_W-1:0] treble,
                              input logic [CFG_DATA_W-1:0] vol_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BASS;
    cfg_data  <= bass;
    @(negedge clk);
    cfg_index <= CFG_TREBLE;
    cfg_data  <= treble;
    @(negedge clk);
    cfg_index <= CFG_VOLUME;
    cfg_data  <= vol_word;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stop offering and wait until every predicted sample has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  // Gain choice: off, musical range, extremes, small positive values, or any 20-bit pattern.
  function automatic logic [GAIN_W-1:0] pick_gain();
    int v;
    case ($urandom_range(0, 5))
      0: return '0;
      1: begin
        v = $urandom_range(0, 5120);
        return v - 2560;
      end
      2: return $urandom;
      3: return GAIN_MAX;
      4: return GAIN_MIN;
      default: return $urandom_range(1, 256);
    endcase
  endfunction

  initial begin
    int                         burst_left;
    int                         gap;
    int                         gap_mode;
    int                         v;
    logic [GAIN_W-1:0]          bass_pick;
    logic [GAIN_W-1:0]          treble_pick;
    logic [VOL_W-1:0]           vol_pick;
    logic [3:0]                 vol_junk;
    logic signed [SAMPLE_W-1:0] smp;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_BASS;
    cfg_data            <= '0;
    in_valid            <= 1'b0;
    in_channel          <= 1'b0;
    in_sample_in        <= '0;
    in_first_of_channel <= 1'b0;
    hold_req            <= 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings (no tone, unity volume): full-scale both ways,
    // zero and one LSB around it.
    push_sample(1'b0, 16'sh8000, 1'b1);
    push_sample(1'b1, 16'sh7fff, 1'b1);
    push_sample(1'b0, 16'sh0000, 1'b0);
    push_sample(1'b1, -16'sd1, 1'b0);
    push_sample(1'b0, 16'sd1, 1'b0);

    // Huge positive gains everywhere: intermediates far past full scale,
    // both clamps engaged.
    wait_drained();
    program_regs(GAIN_MAX, GAIN_MAX, 20'h0ffff);
    push_sample(1'b0, 16'sd12345, 1'b0);
    push_sample(1'b1, -16'sd20000, 1'b0);
    push_sample(1'b0, 16'sh8000, 1'b1);

    // Stray write past the register list must leave the settings alone.
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_UNUSED;
    cfg_data  <= '1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    push_sample(1'b1, 16'sh7fff, 1'b0);

    // Most negative gains: bass cut drives the sign over, treble ignored,
    // volume muted.
    wait_drained();
    program_regs(GAIN_MIN, GAIN_MIN, 20'h00000);
    push_sample(1'b0, 16'sd30000, 1'b0);
    push_sample(1'b1, 16'sh8000, 1'b0);

    // Bass cut to exactly zero gain, treble at one tenth, volume 1.5 with junk
    // in the upper data bits; first-of-channel flags on both channels.
    wait_drained();
    program_regs(-20'sd5120, 20'd256, 20'hf0180);
    push_sample(1'b0, 16'sd16384, 1'b1);
    push_sample(1'b0, -16'sd16384, 1'b0);
    push_sample(1'b1, 16'sd8000, 1'b1);
    push_sample(1'b1, -16'sd8000, 1'b0);
    push_sample(1'b0, 16'sh7fff, 1'b0);

    // Bass doubling with half volume.
    wait_drained();
    program_regs(20'd2560, 20'd0, 20'h00080);
    push_sample(1'b0, 16'sd20000, 1'b0);
    push_sample(1'b1, -16'sd20000, 1'b0);
    push_sample(1'b0, 16'sh8000, 1'b0);

    // Random phases: fresh settings each time, written only once drained.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      bass_pick   = pick_gain();
      treble_pick = pick_gain();
      case ($urandom_range(0, 4))
        0: vol_pick = VOLUME_RESET;
        1: vol_pick = $urandom_range(0, 512);
        2: vol_pick = $urandom;
        3: vol_pick = '0;
        default: vol_pick = '1;
      endcase
      vol_junk = $urandom;
      program_regs(bass_pick, treble_pick, {vol_junk, vol_pick});

      gap_mode = $urandom_range(0, 2);
      // One phase starts with the receiver holding off for a long time
      // while requests keep coming.
      if (phase == 3) hold_req <= 1'b1;
      burst_left = 0;
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = (gap_mode == 0) ? 0 : $urandom_range(1, (gap_mode == 1) ? 3 : 12);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
          end
        end
        burst_left = burst_left - 1;
        case ($urandom_range(0, 3))
          0: smp = $urandom;
          1: begin
            v   = $urandom_range(0, 8191);
            smp = v - 4096;
          end
          2: begin
            v   = $urandom_range(0, 32767);
            smp = v - 16384;
          end
          default: smp = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        endcase
        push_sample($urandom_range(0, 1), smp, $urandom_range(0, 9) == 0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && results_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
